// ===== hw/rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Shared sizes, codes and record layouts of the session counter table.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Table geometry
  localparam int MACHINE_SLOTS        = 16;
  localparam int SESSIONS_PER_MACHINE = 4;
  localparam int MACHINE_ID_BYTES     = 8;
  localparam int SESSION_ID_BYTES     = 8;

  localparam int SESS_DEPTH = MACHINE_SLOTS * SESSIONS_PER_MACHINE;
  localparam int MA_W  = (MACHINE_SLOTS > 1) ? $clog2(MACHINE_SLOTS) : 1;
  localparam int SA_W  = (SESS_DEPTH > 1) ? $clog2(SESS_DEPTH) : 1;
  localparam int SK_W  = (SESSIONS_PER_MACHINE > 1) ? $clog2(SESSIONS_PER_MACHINE) : 1;
  localparam int CNT_W = $clog2(SESSIONS_PER_MACHINE + 1);
  localparam int SCAN_MAX = (MACHINE_SLOTS > SESSIONS_PER_MACHINE) ?
                            MACHINE_SLOTS : SESSIONS_PER_MACHINE;
  localparam int SCAN_W = $clog2(SCAN_MAX + 1);

  // Identifier masks: only the low bytes take part
  localparam logic [63:0] MID_MASK = (MACHINE_ID_BYTES >= 8) ? {64{1'b1}} :
                                     ((64'd1 << (8 * MACHINE_ID_BYTES)) - 64'd1);
  localparam logic [63:0] SID_MASK = (SESSION_ID_BYTES >= 8) ? {64{1'b1}} :
                                     ((64'd1 << (8 * SESSION_ID_BYTES)) - 64'd1);

  typedef enum logic [1:0] {
    REQ_CONNECT, REQ_STATS, REQ_DISCONNECT, REQ_RESERVED
  } req_t;

  typedef enum logic [2:0] {
    STS_OK, STS_NO_MACHINE, STS_NO_SESSION, STS_UNK_MACHINE, STS_UNK_SESSION
  } sts_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MSCAN, S_MPICK, S_SSCAN, S_CALC, S_WRITE, S_OUT
  } state_t;

  typedef struct packed {
    logic [63:0]      machine;
    logic [CNT_W-1:0] open_cnt;
    logic [CNT_W-1:0] search_cnt;
    logic [CNT_W-1:0] prune_cnt;
    logic [31:0]      connects;
    logic [47:0]      first_time;
    logic [47:0]      last_time;
    logic [63:0]      checked_sum;
    logic [63:0]      removed_sum;
    logic [63:0]      best;
    logic [63:0]      uptime;
  } entry_rec_t;

  typedef struct packed {
    logic [63:0] client;
    logic        is_search;
    logic [47:0] start_time;
    logic [63:0] last_checked;
    logic [63:0] last_removed;
  } sess_rec_t;

  // Control into the record update
  typedef struct packed {
    req_t        req;
    logic        sess_hit;
    logic        sess_free;
    logic        new_search;
    logic        ck_ge;
    logic        rm_ge;
    logic        up_gt;
    logic [63:0] ck_delta;
    logic [63:0] rm_delta;
    logic [47:0] up_delta;
  } upd_ctl_t;

  // Outcome of the record update
  typedef struct packed {
    sts_t status;
    logic sess_we;
    logic sess_set;
    logic sess_clr;
  } upd_res_t;

endpackage

// ===== hw/rtl/sct_req_if.sv =====
// ----------------------------------------------------------------------------
// sct_req_if
// Event channel: valid/ready with one event per beat.
// ----------------------------------------------------------------------------
interface sct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] machine_id;
  logic [63:0] session_id;
  logic [7:0]  role_mode;
  logic [47:0] now_seconds;
  logic [63:0] checked_count;
  logic [63:0] removed_count;
  logic [63:0] result_value;

  modport source (output valid, req_type, machine_id, session_id, role_mode,
                  now_seconds, checked_count, removed_count, result_value,
                  input ready);
  modport sink (input valid, req_type, machine_id, session_id, role_mode,
                now_seconds, checked_count, removed_count, result_value,
                output ready);
endinterface

// ===== hw/rtl/sct_res_if.sv =====
// ----------------------------------------------------------------------------
// sct_res_if
// Result channel: valid/ready with one totals report per beat.
// ----------------------------------------------------------------------------
interface sct_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic [2:0]  active_sessions;
  logic [2:0]  active_search;
  logic [2:0]  active_prune;
  logic [31:0] connections_total;
  logic [63:0] total_checked;
  logic [63:0] total_removed;
  logic [63:0] best_result;
  logic [63:0] uptime_total;
  logic [47:0] first_seen_time;
  logic [47:0] last_seen_time;

  modport source (output valid, status, slot, active_sessions, active_search,
                  active_prune, connections_total, total_checked, total_removed,
                  best_result, uptime_total, first_seen_time, last_seen_time,
                  input ready);
  modport sink (input valid, status, slot, active_sessions, active_search,
                active_prune, connections_total, total_checked, total_removed,
                best_result, uptime_total, first_seen_time, last_seen_time,
                output ready);
endinterface

// ===== hw/rtl/sct_ram.sv =====
// ----------------------------------------------------------------------------
// sct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hw/rtl/sct_update.sv =====
// ----------------------------------------------------------------------------
// sct_update
// Record modify step: new machine and session records for one event.
// ----------------------------------------------------------------------------
module sct_update (
  input  sct_pkg::upd_ctl_t   ctl,
  input  sct_pkg::entry_rec_t ent,
  input  sct_pkg::sess_rec_t  sess,
  input  logic [63:0]         sid,
  input  logic [47:0]         now,
  input  logic [63:0]         chk,
  input  logic [63:0]         rem,
  input  logic [63:0]         res,
  output sct_pkg::entry_rec_t ent_new,
  output sct_pkg::sess_rec_t  sess_new,
  output sct_pkg::upd_res_t   outcome
);
  import sct_pkg::*;

  always_comb begin
    ent_new  = ent;
    sess_new = sess;
    outcome  = '{status: STS_OK, sess_we: 1'b0, sess_set: 1'b0, sess_clr: 1'b0};
    ent_new.last_time = now;
    case (ctl.req)
      REQ_CONNECT: begin
        ent_new.connects = ent.connects + 32'd1;
        if (ctl.sess_hit) begin
          // refresh: start time only
          sess_new.start_time = now;
          outcome.sess_we     = 1'b1;
        end else if (ctl.sess_free) begin
          sess_new.client       = sid;
          sess_new.is_search    = ctl.new_search;
          sess_new.start_time   = now;
          sess_new.last_checked = '0;
          sess_new.last_removed = '0;
          outcome.sess_we       = 1'b1;
          outcome.sess_set      = 1'b1;
          ent_new.open_cnt      = ent.open_cnt + CNT_W'(1);
          if (ctl.new_search) begin
            ent_new.search_cnt = ent.search_cnt + CNT_W'(1);
          end else begin
            ent_new.prune_cnt = ent.prune_cnt + CNT_W'(1);
          end
        end else begin
          outcome.status = STS_NO_SESSION;
        end
      end
      REQ_STATS: begin
        if (res > ent.best) begin
          ent_new.best = res;
        end
        if (ctl.sess_hit) begin
          outcome.sess_we = 1'b1;
          if (ctl.ck_ge) begin
            ent_new.checked_sum   = ent.checked_sum + ctl.ck_delta;
            sess_new.last_checked = chk;
          end
          if (ctl.rm_ge) begin
            ent_new.removed_sum   = ent.removed_sum + ctl.rm_delta;
            sess_new.last_removed = rem;
          end
        end else begin
          outcome.status = STS_UNK_SESSION;
        end
      end
      REQ_DISCONNECT: begin
        if (ctl.sess_hit) begin
          outcome.sess_clr = 1'b1;
          if (ctl.up_gt) begin
            ent_new.uptime = ent.uptime + 64'(ctl.up_delta);
          end
          if (ent.open_cnt != '0) begin
            ent_new.open_cnt = ent.open_cnt - CNT_W'(1);
          end
          // stored role decides which count drops
          if (sess.is_search) begin
            if (ent.search_cnt != '0) begin
              ent_new.search_cnt = ent.search_cnt - CNT_W'(1);
            end
          end else if (ent.prune_cnt != '0) begin
            ent_new.prune_cnt = ent.prune_cnt - CNT_W'(1);
          end
        end else begin
          outcome.status = STS_UNK_SESSION;
        end
      end
      default: begin
        outcome.status = STS_UNK_MACHINE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/session_counter_table.sv =====
// ----------------------------------------------------------------------------
// session_counter_table
// Machine and session table with per-machine counters, one report per event.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one event per beat (connect, stats, disconnect) with timestamp.
//   out_ch : one totals report per event, held until the sink takes it.
//   cfg_we / cfg_wdata : sets the role code counted as search; write while idle.
// Sequence: the machine records sit in one RAM and are scanned one per cycle,
//   then the machine's session records in a second RAM, then a delta compute
//   step and a write-back step. An unknown machine, or a new one with no free
//   or idle slot, is reported after the machine pick, with no session scan.
// Flow: one event at a time; the next beat is taken in the cycle after the
//   report is accepted.
// Reset: valid bits of all machine and session slots clear at once, so the
//   tables read as empty with no clearing pass; the role code resets to zero.
// Stall: while out_ch.ready is low the report holds and in_ch.ready stays low.
// Reads and the single write-back never overlap, so no forwarding is needed.
// ----------------------------------------------------------------------------
module session_counter_table (
  input  logic       clk,
  input  logic       rst_n,
  sct_req_if.sink    in_ch,
  sct_res_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import sct_pkg::*;

  // control state
  state_t                 state_r, state_nxt;
  logic [SCAN_W-1:0]      cnt_r, cnt_nxt;
  logic [MACHINE_SLOTS-1:0] ent_valid_r, ent_valid_nxt;
  logic [SESS_DEPTH-1:0]  sess_valid_r, sess_valid_nxt;
  logic [7:0]             cfg_mode_r;

  // latched event
  req_t        req_r, req_nxt;
  logic [63:0] mid_r, mid_nxt, sid_r, sid_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [47:0] now_r, now_nxt;
  logic [63:0] chk_r, chk_nxt, rem_r, rem_nxt, res_r, res_nxt;

  // machine scan results
  logic            hit_r, hit_nxt, free_r, free_nxt, vic_r, vic_nxt;
  logic [MA_W-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [MA_W-1:0] vic_idx_r, vic_idx_nxt, m_r, m_nxt;
  logic [47:0]     oldest_r, oldest_nxt;
  logic            fresh_r, fresh_nxt;
  entry_rec_t      ent_rec_r, ent_rec_nxt;

  // session scan results
  logic            s_hit_r, s_hit_nxt, s_free_r, s_free_nxt;
  logic [SK_W-1:0] s_idx_r, s_idx_nxt, s_free_idx_r, s_free_idx_nxt;
  sess_rec_t       sess_rec_r, sess_rec_nxt;

  // deltas
  upd_ctl_t ctl_r, ctl_nxt;

  // report register
  logic       out_valid_r, out_valid_nxt;
  sts_t       out_sts_r, out_sts_nxt;
  logic [3:0] out_slot_r, out_slot_nxt;
  entry_rec_t out_ent_r, out_ent_nxt;

  // RAM ports
  logic            ent_we, sess_we;
  logic [MA_W-1:0] ent_raddr;
  logic [SA_W-1:0] sess_raddr, sess_waddr, sess_base, sess_prev_addr;
  entry_rec_t      ent_rdata, ent_new;
  sess_rec_t       sess_rdata, sess_new;
  upd_res_t        outcome;

  logic [SCAN_W-1:0] scan_prev;
  logic [MA_W-1:0]   pm;
  logic [SK_W-1:0]   pk, s_sel;
  logic              sv;

  sct_ram #(.WIDTH($bits(entry_rec_t)), .DEPTH(MACHINE_SLOTS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (m_r),
    .wdata (ent_new),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  sct_ram #(.WIDTH($bits(sess_rec_t)), .DEPTH(SESS_DEPTH)) u_sess_ram (
    .clk   (clk),
    .we    (sess_we),
    .waddr (sess_waddr),
    .wdata (sess_new),
    .raddr (sess_raddr),
    .rdata (sess_rdata)
  );

  sct_update u_update (
    .ctl      (ctl_r),
    .ent      (ent_rec_r),
    .sess     (sess_rec_r),
    .sid      (sid_r),
    .now      (now_r),
    .chk      (chk_r),
    .rem      (rem_r),
    .res      (res_r),
    .ent_new  (ent_new),
    .sess_new (sess_new),
    .outcome  (outcome)
  );

  // scan addressing
  assign scan_prev      = cnt_r - SCAN_W'(1);
  assign pm             = scan_prev[MA_W-1:0];
  assign pk             = scan_prev[SK_W-1:0];
  assign sess_base      = SA_W'(m_r) * SA_W'(SESSIONS_PER_MACHINE);
  assign ent_raddr      = cnt_r[MA_W-1:0];
  assign sess_raddr     = sess_base + SA_W'(cnt_r[SK_W-1:0]);
  assign sess_prev_addr = sess_base + SA_W'(pk);
  assign s_sel          = s_hit_r ? s_idx_r : s_free_idx_r;
  assign sess_waddr     = sess_base + SA_W'(s_sel);
  assign ent_we         = (state_r == S_WRITE);
  assign sess_we        = (state_r == S_WRITE) && outcome.sess_we;
  assign sv             = sess_valid_r[sess_prev_addr] && !fresh_r;

  // channel outputs
  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_sts_r;
  assign out_ch.slot              = out_slot_r;
  assign out_ch.active_sessions   = 3'(out_ent_r.open_cnt);
  assign out_ch.active_search     = 3'(out_ent_r.search_cnt);
  assign out_ch.active_prune      = 3'(out_ent_r.prune_cnt);
  assign out_ch.connections_total = out_ent_r.connects;
  assign out_ch.total_checked     = out_ent_r.checked_sum;
  assign out_ch.total_removed     = out_ent_r.removed_sum;
  assign out_ch.best_result       = out_ent_r.best;
  assign out_ch.uptime_total      = out_ent_r.uptime;
  assign out_ch.first_seen_time   = out_ent_r.first_time;
  assign out_ch.last_seen_time    = out_ent_r.last_time;

  // sequencer: next state and datapath loads
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ent_valid_nxt  = ent_valid_r;
    sess_valid_nxt = sess_valid_r;
    req_nxt  = req_r;  mid_nxt = mid_r;  sid_nxt = sid_r;  mode_nxt = mode_r;
    now_nxt  = now_r;  chk_nxt = chk_r;  rem_nxt = rem_r;  res_nxt  = res_r;
    hit_nxt  = hit_r;  hit_idx_nxt = hit_idx_r;
    free_nxt = free_r; free_idx_nxt = free_idx_r;
    vic_nxt  = vic_r;  vic_idx_nxt = vic_idx_r; oldest_nxt = oldest_r;
    m_nxt    = m_r;    fresh_nxt = fresh_r;  ent_rec_nxt = ent_rec_r;
    s_hit_nxt = s_hit_r; s_idx_nxt = s_idx_r;
    s_free_nxt = s_free_r; s_free_idx_nxt = s_free_idx_r;
    sess_rec_nxt  = sess_rec_r;
    ctl_nxt       = ctl_r;
    out_valid_nxt = out_valid_r;
    out_sts_nxt   = out_sts_r;
    out_slot_nxt  = out_slot_r;
    out_ent_nxt   = out_ent_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt    = req_t'(in_ch.req_type);
          mid_nxt    = in_ch.machine_id & MID_MASK;
          sid_nxt    = in_ch.session_id & SID_MASK;
          mode_nxt   = in_ch.role_mode;
          now_nxt    = in_ch.now_seconds;
          chk_nxt    = in_ch.checked_count;
          rem_nxt    = in_ch.removed_count;
          res_nxt    = in_ch.result_value;
          hit_nxt    = 1'b0;
          free_nxt   = 1'b0;
          vic_nxt    = 1'b0;
          s_hit_nxt  = 1'b0;
          s_free_nxt = 1'b0;
          cnt_nxt    = '0;
          state_nxt  = S_MSCAN;
        end
      end

      // one machine record per cycle: match, first free, oldest idle
      S_MSCAN: begin
        cnt_nxt = cnt_r + SCAN_W'(1);
        if (cnt_r != '0) begin
          if (ent_valid_r[pm]) begin
            if (!hit_r && ent_rdata.machine == mid_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = pm;
              ent_rec_nxt = ent_rdata;
            end
            if (ent_rdata.open_cnt == '0 && (!vic_r || ent_rdata.last_time < oldest_r)) begin
              vic_nxt     = 1'b1;
              vic_idx_nxt = pm;
              oldest_nxt  = ent_rdata.last_time;
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pm;
          end
          if (cnt_r == SCAN_W'(MACHINE_SLOTS)) begin
            state_nxt = S_MPICK;
          end
        end
      end

      S_MPICK: begin
        cnt_nxt   = '0;
        fresh_nxt = 1'b0;
        if (req_r == REQ_RESERVED || (!hit_r && req_r != REQ_CONNECT)) begin
          out_sts_nxt   = STS_UNK_MACHINE;
          out_slot_nxt  = '0;
          out_ent_nxt   = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else if (hit_r) begin
          m_nxt     = hit_idx_r;
          state_nxt = S_SSCAN;
        end else if (free_r || vic_r) begin
          // new entry in a free or evicted slot
          m_nxt                  = free_r ? free_idx_r : vic_idx_r;
          fresh_nxt              = 1'b1;
          ent_rec_nxt            = '0;
          ent_rec_nxt.machine    = mid_r;
          ent_rec_nxt.first_time = now_r;
          state_nxt              = S_SSCAN;
        end else begin
          out_sts_nxt   = STS_NO_MACHINE;
          out_slot_nxt  = '0;
          out_ent_nxt   = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end

      // one session record of the chosen machine per cycle
      S_SSCAN: begin
        cnt_nxt = cnt_r + SCAN_W'(1);
        if (cnt_r != '0) begin
          if (sv) begin
            if (!s_hit_r && sess_rdata.client == sid_r) begin
              s_hit_nxt    = 1'b1;
              s_idx_nxt    = pk;
              sess_rec_nxt = sess_rdata;
            end
          end else if (!s_free_r) begin
            s_free_nxt     = 1'b1;
            s_free_idx_nxt = pk;
          end
          if (cnt_r == SCAN_W'(SESSIONS_PER_MACHINE)) begin
            state_nxt = S_CALC;
          end
        end
      end

      // counter growth and uptime
      S_CALC: begin
        ctl_nxt.req        = req_r;
        ctl_nxt.sess_hit   = s_hit_r;
        ctl_nxt.sess_free  = s_free_r;
        ctl_nxt.new_search = (mode_r == cfg_mode_r);
        ctl_nxt.ck_ge      = (chk_r >= sess_rec_r.last_checked);
        ctl_nxt.rm_ge      = (rem_r >= sess_rec_r.last_removed);
        ctl_nxt.up_gt      = (now_r > sess_rec_r.start_time);
        ctl_nxt.ck_delta   = chk_r - sess_rec_r.last_checked;
        ctl_nxt.rm_delta   = rem_r - sess_rec_r.last_removed;
        ctl_nxt.up_delta   = now_r - sess_rec_r.start_time;
        state_nxt          = S_WRITE;
      end

      // write back and load the report
      S_WRITE: begin
        ent_valid_nxt[m_r] = 1'b1;
        if (fresh_r) begin
          for (int k = 0; k < SESSIONS_PER_MACHINE; k++) begin
            sess_valid_nxt[sess_base + SA_W'(k)] = 1'b0;
          end
        end
        if (outcome.sess_set) begin
          sess_valid_nxt[sess_waddr] = 1'b1;
        end
        if (outcome.sess_clr) begin
          sess_valid_nxt[sess_waddr] = 1'b0;
        end
        out_sts_nxt   = outcome.status;
        out_slot_nxt  = 4'(m_r);
        out_ent_nxt   = ent_new;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end

      S_OUT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      ent_valid_r  <= '0;
      sess_valid_r <= '0;
      cfg_mode_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      ent_valid_r  <= ent_valid_nxt;
      sess_valid_r <= sess_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        cfg_mode_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;  mid_r <= mid_nxt;  sid_r <= sid_nxt;  mode_r <= mode_nxt;
    now_r  <= now_nxt;  chk_r <= chk_nxt;  rem_r <= rem_nxt;  res_r  <= res_nxt;
    hit_r  <= hit_nxt;  hit_idx_r <= hit_idx_nxt;
    free_r <= free_nxt; free_idx_r <= free_idx_nxt;
    vic_r  <= vic_nxt;  vic_idx_r <= vic_idx_nxt; oldest_r <= oldest_nxt;
    m_r    <= m_nxt;    fresh_r <= fresh_nxt;   ent_rec_r <= ent_rec_nxt;
    s_hit_r  <= s_hit_nxt;  s_idx_r <= s_idx_nxt;
    s_free_r <= s_free_nxt; s_free_idx_r <= s_free_idx_nxt;
    sess_rec_r <= sess_rec_nxt;
    ctl_r      <= ctl_nxt;
    out_sts_r  <= out_sts_nxt;
    out_slot_r <= out_slot_nxt;
    out_ent_r  <= out_ent_nxt;
  end

  // an accepted beat always starts the machine scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_MSCAN))
    else $error("accepted event did not start the scan");

  // open count is the sum of the role counts
  a_role_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.active_sessions ==
                      3'(out_ch.active_search + out_ch.active_prune)))
    else $error("role counts do not add up to open sessions");

  // no new event while a report is pending
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while report pending");

  // write-back is followed by a report
  a_write_report: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> out_ch.valid)
    else $error("write-back without report");

endmodule
